// File: design/stt_pkg.sv
// shared types, token class codes and keyword table of the source text tokenizer
package stt_pkg;

    localparam int PREFIX_BYTES_DEF = 8;
    localparam int TEXT_W           = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int NUM_WORDS        = 12;

    typedef enum logic [2:0] {
        CLS_NAME     = 3'd0,
        CLS_NUMBER   = 3'd1,
        CLS_BRACKET  = 3'd2,
        CLS_OPERATOR = 3'd3,
        CLS_KEYWORD  = 3'd4
    } t_tok_class;

    // token as closed by the front end, before keyword lookup
    typedef struct packed {
        t_tok_class         cls;
        logic [15:0]        line;
        logic [15:0]        column;
        logic [31:0]        start;
        logic [15:0]        length;
        logic [TEXT_W-1:0]  prefix;
        logic               truncated;
    } t_raw_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [3:0]        len;
        t_tok_class        cls;
    } t_word;

    // words packed first byte in the low bits
    localparam t_word WORD_TABLE [NUM_WORDS] = '{
        '{64'h0000_0000_0074_656c, 4'd3, CLS_KEYWORD},   // let
        '{64'h0000_0074_736e_6f63, 4'd5, CLS_KEYWORD},   // const
        '{64'h0000_0000_0000_6669, 4'd2, CLS_KEYWORD},   // if
        '{64'h0000_6669_6573_6c65, 4'd6, CLS_KEYWORD},   // elseif
        '{64'h0000_0000_0072_6f66, 4'd3, CLS_KEYWORD},   // for
        '{64'h0000_0065_6c69_6877, 4'd5, CLS_KEYWORD},   // while
        '{64'h0000_0000_0000_6e66, 4'd2, CLS_KEYWORD},   // fn
        '{64'h0000_0000_0064_6e65, 4'd3, CLS_KEYWORD},   // end
        '{64'h0000_0000_6570_7974, 4'd4, CLS_KEYWORD},   // type
        '{64'h0000_0000_0074_6f6e, 4'd3, CLS_OPERATOR},  // not
        '{64'h0000_0000_0064_6e61, 4'd3, CLS_OPERATOR},  // and
        '{64'h0000_0000_0000_726f, 4'd2, CLS_OPERATOR}   // or
    };

    function automatic t_tok_class word_class(input t_tok_class cls,
                                              input logic [TEXT_W-1:0] prefix,
                                              input logic [15:0] length);
        t_tok_class res;
        res = cls;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (length == {12'd0, WORD_TABLE[i].len} && prefix == WORD_TABLE[i].text) begin
                res = WORD_TABLE[i].cls;
            end
        end
        return res;
    endfunction

endpackage

// File: design/source_text_tokenizer_unit.sv
// top level of the source text tokenizer
// path: the token that a beat ends goes through the token queue and keyword lookup into the output register
// throughput: one byte beat per cycle; input stalls only when the 4-entry token queue is full,
// which happens only while the master side is held off
// reset: synchronous active-low; clears the open token, the queue and the output register,
// and sets line and column to 1 and the byte offset to 0
module source_text_tokenizer_unit import stt_pkg::*; #(
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side: one source byte per beat
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] char_code
    input  logic         i_s_tlast,   // end_of_text: flush open token, restart positions
    // master side: one token per beat
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [15:0] end_line, [31:16] end_column, [63:32] start_offset, [79:64] token_length,
    // [143:80] text_prefix, [144] prefix_truncated, [151:145] zero
    output logic [151:0] o_m_tdata,
    output logic [2:0]   o_m_tuser    // [2:0] token_class
);

    logic      accept;
    logic      push;
    logic      pop;
    t_raw_tok  front_tok;
    t_raw_tok  queue_tok;
    t_raw_tok  out_tok;
    t_q_status q_status;

    // a byte is taken whenever the queue has room for the token it may close
    assign o_s_tready = !q_status.full;
    assign accept     = i_s_tvalid && o_s_tready;

    stt_front #(
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_s_tdata),
        .i_eot    (i_s_tlast),
        .o_push   (push),
        .o_tok    (front_tok)
    );

    stt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_tok    (front_tok),
        .i_pop    (pop),
        .o_tok    (queue_tok),
        .o_status (q_status)
    );

    // keyword lookup sits between the queue and the output register
    stt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (queue_tok),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_tok      (out_tok)
    );

    assign o_m_tuser = out_tok.cls;
    assign o_m_tdata = {7'd0, out_tok.truncated, out_tok.prefix, out_tok.length,
                        out_tok.start, out_tok.column, out_tok.line};

endmodule

// File: design/stt_front.sv
// front end: classifies each byte, tracks the open token and position counters
module stt_front import stt_pkg::*; #(
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic [7:0] i_char,
    input  logic     i_eot,
    output logic     o_push,
    output t_raw_tok o_tok
);

    localparam int PW = PREFIX_BYTES * 8;

    localparam logic [7:0] CH_NL  = 8'h0a;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_US  = 8'h5f;

    typedef enum logic [2:0] {
        K_LETTER, K_DIGIT, K_BRACKET, K_BLANK, K_OTHER
    } t_kind;

    logic              r_pend_v, n_pend_v;
    t_tok_class        r_cls, n_cls;
    logic [PW-1:0]     r_prefix, n_prefix;
    logic [15:0]       r_len, n_len;
    logic [31:0]       r_start, n_start;
    logic [15:0]       r_line, n_line;
    logic [15:0]       r_col, n_col;
    logic [31:0]       r_off, n_off;
    t_kind             kind;
    logic              extend;
    logic              emit;
    logic              start_new;
    logic [TEXT_W-1:0] prefix_ext;

    always_comb begin
        if (i_char inside {[8'h61:8'h7a], [8'h41:8'h5a], CH_US}) begin
            kind = K_LETTER;
        end else if (i_char inside {[8'h30:8'h39]}) begin
            kind = K_DIGIT;
        end else if (i_char inside {8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d}) begin
            kind = K_BRACKET;
        end else if (i_char inside {CH_SP, CH_TAB, CH_NL}) begin
            kind = K_BLANK;
        end else begin
            kind = K_OTHER;
        end
    end

    always_comb begin
        n_pend_v  = r_pend_v;
        n_cls     = r_cls;
        n_prefix  = r_prefix;
        n_len     = r_len;
        n_start   = r_start;
        n_line    = r_line;
        n_col     = r_col;
        n_off     = r_off;
        extend    = 1'b0;
        emit      = 1'b0;
        start_new = 1'b0;
        if (i_accept) begin
            if (i_eot) begin
                emit     = r_pend_v;
                n_pend_v = 1'b0;
                n_line   = 16'd1;
                n_col    = 16'd1;
                n_off    = 32'd0;
            end else begin
                case (r_cls)
                    CLS_NAME:     extend = (kind == K_LETTER) || (kind == K_DIGIT);
                    CLS_NUMBER:   extend = (kind == K_DIGIT) || (i_char == CH_DOT);
                    CLS_OPERATOR: extend = (kind == K_OTHER);
                    default:      extend = 1'b0;
                endcase
                extend    = extend && r_pend_v;
                emit      = r_pend_v && !extend;
                start_new = (!r_pend_v || emit) && (kind != K_BLANK);
                if (extend) begin
                    for (int i = 0; i < PREFIX_BYTES; i++) begin
                        if (r_len == 16'(i)) begin
                            n_prefix[8*i +: 8] = i_char;
                        end
                    end
                    if (r_len != 16'hffff) begin
                        n_len = r_len + 16'd1;
                    end
                end else if (start_new) begin
                    n_pend_v      = 1'b1;
                    n_prefix      = '0;
                    n_prefix[7:0] = i_char;
                    n_len         = 16'd1;
                    n_start       = r_off;
                    case (kind)
                        K_LETTER:  n_cls = CLS_NAME;
                        K_DIGIT:   n_cls = CLS_NUMBER;
                        K_BRACKET: n_cls = CLS_BRACKET;
                        default:   n_cls = CLS_OPERATOR;
                    endcase
                end else if (emit) begin
                    n_pend_v = 1'b0;
                end
                if (r_off != 32'hffff_ffff) begin
                    n_off = r_off + 32'd1;
                end
                if (i_char == CH_NL) begin
                    if (r_line != 16'hffff) begin
                        n_line = r_line + 16'd1;
                    end
                    n_col = 16'd1;
                end else if (r_col != 16'hffff) begin
                    n_col = r_col + 16'd1;
                end
            end
        end
    end

    always_comb begin
        prefix_ext         = '0;
        prefix_ext[PW-1:0] = r_prefix;
    end

    assign o_push          = emit;
    assign o_tok.cls       = r_cls;
    assign o_tok.line      = r_line;
    assign o_tok.column    = r_col;
    assign o_tok.start     = r_start;
    assign o_tok.length    = r_len;
    assign o_tok.prefix    = prefix_ext;
    assign o_tok.truncated = (r_len > 16'(PREFIX_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_cls    <= CLS_NAME;
            r_line   <= 16'd1;
            r_col    <= 16'd1;
            r_off    <= 32'd0;
        end else begin
            r_pend_v <= n_pend_v;
            r_cls    <= n_cls;
            r_line   <= n_line;
            r_col    <= n_col;
            r_off    <= n_off;
        end
        r_prefix <= n_prefix;
        r_len    <= n_len;
        r_start  <= n_start;
    end

endmodule

// File: design/stt_queue.sv
// short token queue between front and back end
module stt_queue import stt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_raw_tok  i_tok,
    input  logic      i_pop,
    output t_raw_tok  o_tok,
    output t_q_status o_status
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_raw_tok        r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_tok          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

// File: design/stt_back.sv
// back end: keyword lookup and output register
module stt_back import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_raw_tok   i_tok,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_raw_tok   o_tok
);

    logic     r_valid;
    t_raw_tok r_tok;
    t_raw_tok n_tok;

    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

    always_comb begin
        n_tok     = i_tok;
        n_tok.cls = word_class(i_tok.cls, i_tok.prefix, i_tok.length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_tok <= n_tok;
        end
    end

endmodule

// File: design/stt_checker.sv
// port-level checks for the source text tokenizer, bound to the top level
module stt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [7:0]   i_s_tdata,
    input logic         i_s_tlast,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [151:0] o_m_tdata,
    input logic [2:0]   o_m_tuser
);

    // output beat held while stalled
    a_m_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("master tvalid dropped while stalled");

    a_m_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("master beat changed while stalled");

    // no token on the first cycle after reset is released
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !o_m_tvalid)
        else $error("master tvalid after reset");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= 3'd4)
        else $error("token class out of range");

    // every token has a length and a position of at least one
    a_fields_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[79:64] != 16'd0 && o_m_tdata[15:0] != 16'd0
                       && o_m_tdata[31:16] != 16'd0)
        else $error("token length, line or column is zero");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);

// File: tb/source_text_tokenizer_unit_test.sv
// self-checking testbench for the source text tokenizer: byte stream in, token beats checked
`timescale 1ns / 1ps

module source_text_tokenizer_unit_test;
    import stt_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  RANDOM_BEATS = 900;
    localparam int  LONG_RUN    = 20;      // well past the eight-byte prefix
    localparam int  MAX_SHOWN   = 10;

    // byte classes as the scanner sees them
    typedef enum int {K_LETTER, K_DIGIT, K_BRACKET, K_BLANK, K_OTHER} t_char_kind;

    // one token as it should appear on the master side
    typedef struct packed {
        t_tok_class  cls;
        logic [15:0] line;
        logic [15:0] col;
        logic [31:0] start;
        logic [15:0] len;
        logic [63:0] prefix;
        logic        trunc;
    } t_token;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata;   // [7:0] char_code
    logic         i_s_tlast;   // end_of_text
    logic         o_m_tvalid;
    logic         i_m_tready;
    // [15:0] end_line, [31:16] end_column, [63:32] start_offset, [79:64] token_length,
    // [143:80] text_prefix, [144] prefix_truncated, [151:145] zero
    logic [151:0] o_m_tdata;
    logic [2:0]   o_m_tuser;   // [2:0] token_class

    source_text_tokenizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // scanner mirror: the open token and the position counters
    logic        tok_open;
    t_tok_class  tok_cls;
    logic [63:0] tok_prefix;
    logic [15:0] tok_len;
    logic [31:0] tok_start;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [31:0] byte_pos;

    t_token tokens_due[$];     // tokens predicted but not yet seen on the master side

    logic idle_on;             // random idling on both sides
    int   cycle_count;
    int   beats_sent;
    int   tokens_checked;
    int   bad_tokens;
    int   class_seen [5];

    string letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string digit_set  = "0123456789";
    string bracket_set = "()[]{}";
    string blank_set  = " \t\n";
    // reserved words plus near misses that must stay plain names
    string word_list [18] = '{"let", "const", "if", "elseif", "for", "while", "fn", "end",
                              "type", "not", "and", "or", "elsei", "iff", "fn_", "ends",
                              "Or", "typed"};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still due",
                     cycle_count, tokens_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_char_kind kind_of(input logic [7:0] ch);
        if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_")
            return K_LETTER;
        if (ch >= "0" && ch <= "9")
            return K_DIGIT;
        if (ch == "(" || ch == ")" || ch == "[" || ch == "]" || ch == "{" || ch == "}")
            return K_BRACKET;
        if (ch == " " || ch == "\t" || ch == "\n")
            return K_BLANK;
        return K_OTHER;
    endfunction

    // reserved word lookup; only names can spell a word, and a saturated
    // length is far above eight so it never matches
    function automatic t_tok_class resolve_class(input t_tok_class cls,
                                                 input logic [63:0] prefix,
                                                 input logic [15:0] len);
        string s;
        s = "";
        if (cls != CLS_NAME || len > 16'd8)
            return cls;
        for (int i = 0; i < len; i++) begin
            s = {s, " "};
            s.putc(i, prefix[8*i +: 8]);
        end
        case (s)
            "let", "const", "if", "elseif", "for", "while", "fn", "end", "type":
                return CLS_KEYWORD;
            "not", "and", "or":
                return CLS_OPERATOR;
            default:
                return cls;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] ch);
        if (tok_len < 16'd8)
            tok_prefix[8*tok_len +: 8] = ch;
        if (tok_len != 16'hFFFF)
            tok_len++;
    endtask

    // closes the open token at the current position
    task automatic close_token();
        t_token t;
        t.cls    = resolve_class(tok_cls, tok_prefix, tok_len);
        t.line   = line_no;
        t.col    = col_no;
        t.start  = tok_start;
        t.len    = tok_len;
        t.prefix = tok_prefix;
        t.trunc  = (tok_len > 16'd8);
        tokens_due = {tokens_due, t};
        tok_open   = 1'b0;
        tok_cls    = CLS_NAME;
        tok_prefix = '0;
        tok_len    = '0;
        tok_start  = '0;
    endtask

    // advances the scanner mirror by one accepted byte beat
    task automatic tokenize_beat(input logic [7:0] ch, input logic eot);
        t_char_kind k;
        logic       grow;
        if (eot) begin
            if (tok_open)
                close_token();
            line_no  = 16'd1;
            col_no   = 16'd1;
            byte_pos = '0;
            return;
        end
        k = kind_of(ch);
        if (tok_open) begin
            case (tok_cls)
                CLS_NAME:     grow = (k == K_LETTER || k == K_DIGIT);
                CLS_NUMBER:   grow = (k == K_DIGIT || ch == ".");
                CLS_OPERATOR: grow = (k == K_OTHER);
                default:      grow = 1'b0;   // a bracket is always one byte
            endcase
            if (grow)
                add_byte(ch);
            else
                close_token();
        end
        if (!tok_open && k != K_BLANK) begin
            tok_open = 1'b1;
            case (k)
                K_LETTER:  tok_cls = CLS_NAME;
                K_DIGIT:   tok_cls = CLS_NUMBER;
                K_BRACKET: tok_cls = CLS_BRACKET;
                default:   tok_cls = CLS_OPERATOR;
            endcase
            tok_prefix = '0;
            tok_len    = '0;
            tok_start  = byte_pos;
            add_byte(ch);
        end
        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos++;
        if (ch == "\n") begin
            if (line_no != 16'hFFFF)
                line_no++;
            col_no = 16'd1;
        end else if (col_no != 16'hFFFF) begin
            col_no++;
        end
    endtask

    // sends one byte beat; entered and left just after a falling edge
    task automatic push_beat(input logic [7:0] ch, input logic eot);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 18) begin
                i_s_tvalid = 1'b0;
                i_s_tdata  = 8'($urandom);
                i_s_tlast  = 1'($urandom);
                @(negedge i_clk);
            end
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = ch;
        i_s_tlast  = eot;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        tokenize_beat(ch, eot);
        beats_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // master side: random hold-offs, now and then a longer one to fill the token queue
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 99) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(5, 10)) @(negedge i_clk);
            end
            i_m_tready = !idle_on || ($urandom_range(0, 99) >= 12);
        end
    end

    task automatic flag_mismatch(input string what, input t_token want, input t_token got);
        bad_tokens++;
        if (bad_tokens <= MAX_SHOWN) begin
            $display("mismatch (%s) at cycle %0d", what, cycle_count);
            $display("  expected cls %0d line %0d col %0d start %0d len %0d prefix %h trunc %0b",
                     want.cls, want.line, want.col, want.start, want.len, want.prefix,
                     want.trunc);
            $display("  actual   cls %0d line %0d col %0d start %0d len %0d prefix %h trunc %0b",
                     got.cls, got.line, got.col, got.start, got.len, got.prefix, got.trunc);
        end
    endtask

    // token checker: every accepted master beat against the oldest prediction
    t_token got_tok;
    t_token want_tok;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_tok.cls    = t_tok_class'(o_m_tuser);
            got_tok.line   = o_m_tdata[15:0];
            got_tok.col    = o_m_tdata[31:16];
            got_tok.start  = o_m_tdata[63:32];
            got_tok.len    = o_m_tdata[79:64];
            got_tok.prefix = o_m_tdata[143:80];
            got_tok.trunc  = o_m_tdata[144];
            if (tokens_due.size() == 0) begin
                flag_mismatch("token with none due", '0, got_tok);
            end else begin
                want_tok = tokens_due.pop_front();
                tokens_checked++;
                if (want_tok.cls <= CLS_KEYWORD)
                    class_seen[want_tok.cls]++;
                if (got_tok.cls !== want_tok.cls || got_tok.line !== want_tok.line ||
                    got_tok.col !== want_tok.col || got_tok.start !== want_tok.start ||
                    got_tok.len !== want_tok.len || got_tok.prefix !== want_tok.prefix ||
                    got_tok.trunc !== want_tok.trunc)
                    flag_mismatch("field", want_tok, got_tok);
            end
        end
    end

    // first token after reset starts at offset 0, line 1
    task automatic test_first_token();
        push_text("abc ");
    endtask

    // every class, brackets back to back, numbers with dots, odd operator bytes,
    // end marker with a token open and with none open
    task automatic test_token_classes();
        push_text("if(x)not[9.]{+\t");
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat("\r", 1'b0);
        push_beat(8'hFF, 1'b1);   // flushes the operator run, char ignored
        push_beat(8'h00, 1'b1);   // nothing open: no token
    endtask

    // operator run and name longer than the prefix, then a few lines counted
    task automatic test_long_tokens();
        for (int i = 0; i < LONG_RUN; i++)
            push_beat("+", 1'b0);
        push_beat(" ", 1'b0);
        for (int i = 0; i < LONG_RUN; i++)
            push_beat(pick(letter_set), 1'b0);
        push_beat(8'h00, 1'b1);
        for (int i = 0; i < 5; i++)
            push_beat("\n", 1'b0);
        push_text("z9");
        push_beat(8'h5A, 1'b1);
    endtask

    // mostly well-formed text: words, names, numbers, brackets, operator runs,
    // separators, and some raw noise and end markers
    task automatic test_random_text();
        int         first_beat;
        int         r;
        int         n;
        logic [7:0] ch;
        first_beat = beats_sent;
        while (beats_sent - first_beat < RANDOM_BEATS) begin
            // a long stretch with no idling at the start of this phase
            idle_on = (beats_sent - first_beat) > 300;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                push_text(word_list[$urandom_range(0, 17)]);
            end else if (r < 50) begin
                push_beat(pick(letter_set), 1'b0);
                n = $urandom_range(0, 11);
                for (int i = 0; i < n; i++)
                    push_beat($urandom_range(0, 3) == 0 ? pick(digit_set) : pick(letter_set),
                              1'b0);
            end else if (r < 62) begin
                push_beat(pick(digit_set), 1'b0);
                n = $urandom_range(0, 9);
                for (int i = 0; i < n; i++)
                    push_beat($urandom_range(0, 3) == 0 ? 8'h2E : pick(digit_set), 1'b0);
            end else if (r < 72) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_beat(pick(bracket_set), 1'b0);
            end else if (r < 85) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    do ch = 8'($urandom); while (kind_of(ch) != K_OTHER);
                    push_beat(ch, 1'b0);
                end
            end else if (r < 94) begin
                push_beat(8'($urandom), 1'b0);
            end else begin
                push_beat(8'($urandom), 1'b1);
            end
            if ($urandom_range(0, 99) < 70) begin
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++)
                    push_beat(pick(blank_set), 1'b0);
            end
        end
        push_beat(8'($urandom), 1'b1);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        idle_on    = 1'b1;
        cycle_count    = 0;
        beats_sent     = 0;
        tokens_checked = 0;
        bad_tokens     = 0;
        foreach (class_seen[i])
            class_seen[i] = 0;
        // mirror starts from the reset state
        tok_open   = 1'b0;
        tok_cls    = CLS_NAME;
        tok_prefix = '0;
        tok_len    = '0;
        tok_start  = '0;
        line_no    = 16'd1;
        col_no     = 16'd1;
        byte_pos   = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_token();
        test_token_classes();
        test_long_tokens();
        test_random_text();

        // drain, then allow for the registered output
        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d byte beats, checked %0d tokens in %0d cycles", beats_sent,
                 tokens_checked, cycle_count);
        $display("names %0d numbers %0d brackets %0d operators %0d keywords %0d, %0d bad",
                 class_seen[CLS_NAME], class_seen[CLS_NUMBER], class_seen[CLS_BRACKET],
                 class_seen[CLS_OPERATOR], class_seen[CLS_KEYWORD], bad_tokens);
        if (bad_tokens == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
